### design/kti_pkg.sv
package kti_pkg;

    localparam int KIN_W       = 14;
    localparam int KCFG_W      = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int SEG_W       = 3;
    localparam int OFS_W       = 10;
    localparam int RATIO_W     = 10;
    localparam int CH_W        = 8;
    localparam int NUM_CH      = 3;
    localparam int NUM_SEG     = 5;

    // Per-mille ratio: offset * RECIP >> RECIP_SHIFT equals offset * 1000 / span
    // exactly, because offset stays below 1024 and the rounding excess below the span.
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 20;
    localparam int RPROD_W     = OFS_W + RECIP_W;

    // Division of the scaled difference by 1000, exact for values below 2^18.
    localparam int SCALE_W     = CH_W + RATIO_W;
    localparam int DIV_RECIP_W = 17;
    localparam int DIV_SHIFT   = 26;
    localparam int DPROD_W     = SCALE_W + DIV_RECIP_W;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 17'd67109;

    localparam logic [CFG_IDX_W-1:0] REG_KELVIN_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KELVIN_MAX = 1'd1;

    localparam logic [KCFG_W-1:0] K_TABLE_LOW  = 13'd2700;
    localparam logic [KCFG_W-1:0] K_TABLE_HIGH = 13'd6500;

    localparam logic [KCFG_W-1:0] POINT_K [0:NUM_SEG] = '{
        13'd2700, 13'd3000, 13'd3900, 13'd4500, 13'd5500, 13'd6500
    };

    // Index 0 is red, 1 green, 2 blue.
    typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

    typedef struct packed {
        logic             vld_res;
        logic [SEG_W-1:0] seg;
        logic [OFS_W-1:0] offset;
    } loc_t;

    typedef struct packed {
        logic               vld_res;
        logic [SEG_W-1:0]   seg;
        logic [RATIO_W-1:0] ratio;
    } rat_t;

    function automatic logic [RECIP_W-1:0] seg_recip(input logic [SEG_W-1:0] seg);
        logic [RECIP_W-1:0] r;
        case (seg)
            3'd0:    r = 22'd3495254;   // span 300
            3'd1:    r = 22'd1165085;   // span 900
            3'd2:    r = 22'd1747627;   // span 600
            3'd3:    r = 22'd1048576;   // span 1000
            default: r = 22'd1048576;   // span 1000
        endcase
        return r;
    endfunction

    function automatic rgb_t point_rgb(input logic [SEG_W-1:0] pt);
        rgb_t c;
        case (pt)
            3'd0:    c = {8'd87,  8'd169, 8'd255};
            3'd1:    c = {8'd107, 8'd180, 8'd255};
            3'd2:    c = {8'd171, 8'd213, 8'd255};
            3'd3:    c = {8'd206, 8'd228, 8'd255};
            3'd4:    c = {8'd237, 8'd242, 8'd255};
            default: c = {8'd253, 8'd249, 8'd255};
        endcase
        return c;
    endfunction

endpackage

### design/kelvin_to_rgb_interpolator_top.sv
// Channel   Handshake                  Payload
// input     s_valid / s_ready          s_kelvin[13:0]
// result    m_valid / m_ready          m_valid_res, m_red[7:0], m_green[7:0], m_blue[7:0]
// config    cfg_wr_en (no wait)        cfg_wr_idx[0], cfg_wr_data[12:0]
//
// Four register stages: locate, ratio multiply, scale multiply, divide and add.
// One transaction is accepted per cycle while s_ready is high; its result reaches m_valid
// through the locate, ratio, scale and output registers in that order.
// Each stage takes new data when it is empty or its successor moves, so bubbles close up.
// Reset clears all stage valid bits and loads the limits with 2700 K and 6500 K.
module kelvin_to_rgb_interpolator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [kti_pkg::KIN_W-1:0]       s_kelvin,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_valid_res,
    output logic [kti_pkg::CH_W-1:0]        m_red,
    output logic [kti_pkg::CH_W-1:0]        m_green,
    output logic [kti_pkg::CH_W-1:0]        m_blue,
    input  logic                            cfg_wr_en,
    input  logic [kti_pkg::CFG_IDX_W-1:0]   cfg_wr_idx,
    input  logic [kti_pkg::KCFG_W-1:0]      cfg_wr_data
);

    logic [kti_pkg::KCFG_W-1:0] kelvin_min;
    logic [kti_pkg::KCFG_W-1:0] kelvin_max;
    logic                       rat_valid;
    logic                       rat_ready;
    kti_pkg::rat_t              rat_data;

    kti_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data),
        .kelvin_min  (kelvin_min),
        .kelvin_max  (kelvin_max)
    );

    kti_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kelvin   (s_kelvin),
        .kelvin_min (kelvin_min),
        .kelvin_max (kelvin_max),
        .out_valid  (rat_valid),
        .out_ready  (rat_ready),
        .out_data   (rat_data)
    );

    kti_blend u_blend (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (rat_valid),
        .in_ready    (rat_ready),
        .in_data     (rat_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_valid_res (m_valid_res),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue)
    );

endmodule

### design/kti_cfg.sv
module kti_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [kti_pkg::CFG_IDX_W-1:0]   cfg_wr_idx,
    input  logic [kti_pkg::KCFG_W-1:0]      cfg_wr_data,
    output logic [kti_pkg::KCFG_W-1:0]      kelvin_min,
    output logic [kti_pkg::KCFG_W-1:0]      kelvin_max
);

    logic [kti_pkg::KCFG_W-1:0] kelvin_min_reg;
    logic [kti_pkg::KCFG_W-1:0] kelvin_max_reg;
    logic [kti_pkg::KCFG_W-1:0] limit_next;

    // Limits are saturated into the table range so the datapath never extrapolates.
    always_comb begin
        if (cfg_wr_data < kti_pkg::K_TABLE_LOW) begin
            limit_next = kti_pkg::K_TABLE_LOW;
        end else if (cfg_wr_data > kti_pkg::K_TABLE_HIGH) begin
            limit_next = kti_pkg::K_TABLE_HIGH;
        end else begin
            limit_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kelvin_min_reg <= kti_pkg::K_TABLE_LOW;
            kelvin_max_reg <= kti_pkg::K_TABLE_HIGH;
        end else if (cfg_wr_en) begin
            case (cfg_wr_idx)
                kti_pkg::REG_KELVIN_MIN: kelvin_min_reg <= limit_next;
                kti_pkg::REG_KELVIN_MAX: kelvin_max_reg <= limit_next;
                default: ;
            endcase
        end
    end

    assign kelvin_min = kelvin_min_reg;
    assign kelvin_max = kelvin_max_reg;

endmodule

### design/kti_front.sv
module kti_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [kti_pkg::KIN_W-1:0]     s_kelvin,
    input  logic [kti_pkg::KCFG_W-1:0]    kelvin_min,
    input  logic [kti_pkg::KCFG_W-1:0]    kelvin_max,
    output logic                          out_valid,
    input  logic                          out_ready,
    output kti_pkg::rat_t                 out_data
);

    logic                          s1_valid_reg;
    kti_pkg::loc_t                 s1_loc_reg;
    kti_pkg::loc_t                 s1_loc_next;
    logic                          s1_ready;

    logic                          s2_valid_reg;
    kti_pkg::rat_t                 s2_rat_reg;
    kti_pkg::rat_t                 s2_rat_next;
    logic                          s2_ready;

    logic                          in_window;
    logic [kti_pkg::SEG_W-1:0]     seg;
    logic [kti_pkg::KIN_W-1:0]     k_delta;
    logic [kti_pkg::RPROD_W-1:0]   ratio_prod;

    // Stage 1: window check, segment search and offset into the segment.
    always_comb begin
        in_window = (s_kelvin >= {1'b0, kelvin_min}) && (s_kelvin <= {1'b0, kelvin_max});
        seg = kti_pkg::SEG_W'(kti_pkg::NUM_SEG - 1);
        // Walk downward so the lowest matching segment wins.
        for (int c = kti_pkg::NUM_SEG - 1; c >= 0; c--) begin
            if (s_kelvin <= {1'b0, kti_pkg::POINT_K[c+1]}) begin
                seg = kti_pkg::SEG_W'(c);
            end
        end
        k_delta = s_kelvin - {1'b0, kti_pkg::POINT_K[0]};
        for (int c = 1; c < kti_pkg::NUM_SEG; c++) begin
            if (seg == kti_pkg::SEG_W'(c)) begin
                k_delta = s_kelvin - {1'b0, kti_pkg::POINT_K[c]};
            end
        end
        s1_loc_next.vld_res = in_window;
        s1_loc_next.seg     = in_window ? seg : '0;
        s1_loc_next.offset  = in_window ? k_delta[kti_pkg::OFS_W-1:0] : '0;
    end

    // Stage 2: per-mille ratio by reciprocal multiplication.
    always_comb begin
        ratio_prod = kti_pkg::RPROD_W'(s1_loc_reg.offset)
                   * kti_pkg::RPROD_W'(kti_pkg::seg_recip(s1_loc_reg.seg));
        s2_rat_next.vld_res = s1_loc_reg.vld_res;
        s2_rat_next.seg     = s1_loc_reg.seg;
        s2_rat_next.ratio   =
            ratio_prod[kti_pkg::RECIP_SHIFT +: kti_pkg::RATIO_W];
    end

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && s_valid) begin
            s1_loc_reg <= s1_loc_next;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_rat_reg <= s2_rat_next;
        end
    end

    assign s_ready   = s1_ready;
    assign out_valid = s2_valid_reg;
    assign out_data  = s2_rat_reg;

endmodule

### design/kti_blend.sv
module kti_blend (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  kti_pkg::rat_t               in_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_valid_res,
    output logic [kti_pkg::CH_W-1:0]    m_red,
    output logic [kti_pkg::CH_W-1:0]    m_green,
    output logic [kti_pkg::CH_W-1:0]    m_blue
);

    logic                                              s3_valid_reg;
    logic                                              s3_vld_res_reg;
    kti_pkg::rgb_t                                     s3_lo_reg;
    logic [kti_pkg::NUM_CH-1:0][kti_pkg::SCALE_W-1:0]  s3_scaled_reg;
    kti_pkg::rgb_t                                     s3_lo_next;
    kti_pkg::rgb_t                                     s3_hi;
    logic [kti_pkg::NUM_CH-1:0][kti_pkg::SCALE_W-1:0]  s3_scaled_next;
    logic                                              s3_ready;

    logic                                              out_valid_reg;
    logic                                              out_vld_res_reg;
    kti_pkg::rgb_t                                     out_rgb_reg;
    kti_pkg::rgb_t                                     out_rgb_next;
    logic                                              out_ready;

    logic [kti_pkg::DPROD_W-1:0]                       div_prod;
    logic [kti_pkg::CH_W:0]                            ch_sum;

    // Stage 3: scale each channel's rise across the segment by the ratio.
    // Every channel of the white table is nondecreasing with temperature.
    always_comb begin
        s3_lo_next = kti_pkg::point_rgb(in_data.seg);
        s3_hi      = kti_pkg::point_rgb(in_data.seg + kti_pkg::SEG_W'(1));
        for (int c = 0; c < kti_pkg::NUM_CH; c++) begin
            s3_scaled_next[c] = kti_pkg::SCALE_W'(s3_hi[c] - s3_lo_next[c])
                              * kti_pkg::SCALE_W'(in_data.ratio);
        end
    end

    // Stage 4: divide by 1000 through a reciprocal, add the segment's low color.
    always_comb begin
        div_prod     = '0;
        ch_sum       = '0;
        out_rgb_next = '0;
        for (int c = 0; c < kti_pkg::NUM_CH; c++) begin
            div_prod = kti_pkg::DPROD_W'(s3_scaled_reg[c])
                     * kti_pkg::DPROD_W'(kti_pkg::DIV_RECIP);
            ch_sum   = {1'b0, s3_lo_reg[c]}
                     + {1'b0, div_prod[kti_pkg::DIV_SHIFT +: kti_pkg::CH_W]};
            if (!s3_vld_res_reg) begin
                out_rgb_next[c] = '0;
            end else if (ch_sum[kti_pkg::CH_W]) begin
                out_rgb_next[c] = '1;
            end else begin
                out_rgb_next[c] = ch_sum[kti_pkg::CH_W-1:0];
            end
        end
    end

    assign out_ready = !out_valid_reg || m_ready;
    assign s3_ready  = !s3_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s3_ready) begin
                s3_valid_reg <= in_valid;
            end
            if (out_ready) begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_ready && in_valid) begin
            s3_vld_res_reg <= in_data.vld_res;
            s3_lo_reg      <= s3_lo_next;
            s3_scaled_reg  <= s3_scaled_next;
        end
        if (out_ready && s3_valid_reg) begin
            out_vld_res_reg <= s3_vld_res_reg;
            out_rgb_reg     <= out_rgb_next;
        end
    end

    assign in_ready    = s3_ready;
    assign m_valid     = out_valid_reg;
    assign m_valid_res = out_vld_res_reg;
    assign m_red       = out_rgb_reg[0];
    assign m_green     = out_rgb_reg[1];
    assign m_blue      = out_rgb_reg[2];

endmodule

### design/kti_checker.sv
module kti_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_ready,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_valid_res,
    input  logic [kti_pkg::CH_W-1:0]        m_red,
    input  logic [kti_pkg::CH_W-1:0]        m_green,
    input  logic [kti_pkg::CH_W-1:0]        m_blue
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_valid_res) && $stable(m_red)
            && $stable(m_green) && $stable(m_blue))
        else $error("result changed while stalled");

    // The pipeline only pushes back once the output register is full.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with an empty output register");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_red == '0 && m_green == '0 && m_blue == '0)
        else $error("out-of-window result carries color");

    // In-window colors lie on the white table, between its end points.
    a_on_table: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_valid_res |-> m_red == 8'd255 && m_green >= 8'd169
            && m_green <= 8'd249 && m_blue >= 8'd87 && m_blue <= 8'd253)
        else $error("interpolated color off the white table");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result presented right after reset");

endmodule

bind kelvin_to_rgb_interpolator_top kti_checker u_kti_checker (.*);
